FILE: design/ecg_sample_filter_chain_core_defines.svh
// assertion macros shared by the filter chain rtl
// no dependencies; pulled in by the top level with `include
`ifndef ECG_SAMPLE_FILTER_CHAIN_CORE_DEFINES_SVH
`define ECG_SAMPLE_FILTER_CHAIN_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ESFC_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esfc same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ESFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esfc next-cycle check failed");

`endif

FILE: design/esfc_pkg.sv
// shared types, widths, register indexes and fir coefficient table
// for the ecg sample filter chain; no dependencies
`timescale 1ns / 1ps

package esfc_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int OPND_W         = 33;
    localparam int PROD_W         = 66;
    localparam int ACC_W          = 72;
    localparam int RAW_W          = 24;
    localparam int STATUS_W       = 8;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int READY_BIT_POS  = 5;
    localparam int IIR_TERMS      = 5;
    localparam int FIXED_TAPS     = 36;
    localparam int COEF_IDX_W     = 6;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_MIDPOINT     = 4'd0,
        CFG_CONVERSION_SCALE = 4'd1,
        CFG_OUTPUT_GAIN      = 4'd2,
        CFG_IIR_B0           = 4'd3,
        CFG_IIR_B1           = 4'd4,
        CFG_IIR_B2           = 4'd5,
        CFG_IIR_A1           = 4'd6,
        CFG_IIR_A2           = 4'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [23:0]        RST_ADC_MIDPOINT     = 24'd4194304;
    localparam logic [31:0]        RST_CONVERSION_SCALE = 32'd111358771;
    localparam logic [23:0]        RST_OUTPUT_GAIN      = 24'd65536;
    localparam logic signed [31:0] RST_IIR_B0           = 32'sd952079023;
    localparam logic signed [31:0] RST_IIR_B1           = -32'sd1904158046;
    localparam logic signed [31:0] RST_IIR_B2           = 32'sd952079023;
    localparam logic signed [31:0] RST_IIR_A1           = -32'sd2136449255;
    localparam logic signed [31:0] RST_IIR_A2           = 32'sd1062809798;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCALE_RND,
        ST_IIR,
        ST_IIR_DRAIN,
        ST_IIR_RND,
        ST_FIR,
        ST_FIR_DRAIN,
        ST_FIR_RND,
        ST_GAIN,
        ST_GAIN_RND
    } t_state;

    // per-cycle control of the delay line cells
    typedef struct packed {
        logic rotate;   // take value from the older neighbor (ring rotation)
        logic shift;    // take value from the newer neighbor (insert new sample)
    } t_cell_ctrl;

    // per-cycle control of the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;    // product of this cycle is accumulated next cycle
        logic clear;    // start a fresh sum with this product
        logic sub;      // subtract instead of add
    } t_mac_op;

    localparam logic signed [31:0] FIR_COEF [FIXED_TAPS] = '{
        32'sd853968,     -32'sd313082,    -32'sd1927216,   -32'sd3405812,
        -32'sd3216222,   32'sd251717,     32'sd6789151,    32'sd12959334,
        32'sd12965508,   32'sd2274926,    -32'sd17739761,  -32'sd37402164,
        -32'sd41251658,  -32'sd15396201,  32'sd43756075,   32'sd124539513,
        32'sd202579713,  32'sd250553113,  32'sd250553113,  32'sd202579713,
        32'sd124539513,  32'sd43756075,   -32'sd15396201,  -32'sd41251658,
        -32'sd37402164,  -32'sd17739761,  32'sd2274926,    32'sd12965508,
        32'sd12959334,   32'sd6789151,    32'sd251717,     -32'sd3216222,
        -32'sd3405812,   -32'sd1927216,   -32'sd313082,    32'sd853968
    };

    // coefficient for the tap of a given age; ages past the fixed set are zero
    function automatic logic signed [31:0] fir_coef(input logic [7:0] age);
        logic signed [31:0] c;
        c = '0;
        if (age < 8'(FIXED_TAPS)) begin
            c = FIR_COEF[age[COEF_IDX_W-1:0]];
        end
        return c;
    endfunction

    // clamp a wide signed value to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 72'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -72'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: design/esfc_tap_cell.sv
// one delay line cell of the fir: holds a single past sample
// depends on esfc_pkg for the cell control struct and widths
`timescale 1ns / 1ps

module esfc_tap_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  esfc_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [esfc_pkg::SAMPLE_W-1:0] i_shift_in,
    input  logic signed [esfc_pkg::SAMPLE_W-1:0] i_rot_in,
    output logic signed [esfc_pkg::SAMPLE_W-1:0] o_value
);

    logic signed [esfc_pkg::SAMPLE_W-1:0] r_value;
    logic signed [esfc_pkg::SAMPLE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_value = i_shift_in;
        end else if (i_ctrl.rotate) begin
            n_value = i_rot_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

FILE: design/esfc_mac.sv
// shared signed multiplier with registered product and exact accumulator
// depends on esfc_pkg for widths and the mac op struct
`timescale 1ns / 1ps

module esfc_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  esfc_pkg::t_mac_op                    i_op,
    input  logic signed [esfc_pkg::OPND_W-1:0]   i_opnd_a,
    input  logic signed [esfc_pkg::OPND_W-1:0]   i_opnd_b,
    output logic signed [esfc_pkg::PROD_W-1:0]   o_prod,
    output logic signed [esfc_pkg::ACC_W-1:0]    o_acc
);

    logic signed [esfc_pkg::PROD_W-1:0] r_prod;
    esfc_pkg::t_mac_op                  r_op;
    logic signed [esfc_pkg::ACC_W-1:0]  r_acc;
    logic signed [esfc_pkg::ACC_W-1:0]  w_prod_ext;
    logic signed [esfc_pkg::ACC_W-1:0]  w_base;
    logic signed [esfc_pkg::ACC_W-1:0]  n_acc;

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_opnd_a * i_opnd_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
    end

    // accumulate stage
    always_comb begin
        w_prod_ext = esfc_pkg::ACC_W'(r_prod);
        w_base     = r_op.clear ? '0 : r_acc;
        n_acc      = r_op.sub ? (w_base - w_prod_ext) : (w_base + w_prod_ext);
    end

    always_ff @(posedge i_clk) begin
        if (r_op.issue) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

FILE: design/ecg_sample_filter_chain_core.sv
// ecg sample filter chain: convert, iir high-pass, fir low-pass, gain
// user guide: each accepted item is one converter word (24-bit raw code and a
// status byte). with status bit 5 set the code is centered on adc_midpoint and
// scaled by conversion_scale to q16.16; with it clear the last scaled value is
// reused and sample_held is flagged. the value runs through a direct form i
// biquad (q2.30 coefficients from the register port), then a TAP_COUNT-tap fir
// with fixed coefficients, then the q8.16 output gain; every stage rounds half
// up and saturates to 32 bits. one result item per input item. the block works
// on one item at a time through a single shared 33x33 multiplier: a new item
// is taken only in idle, once the last one has been through the gain step and
// has moved into the output register; a finished result waits while that
// register is still full. the multiplier forms the scaling product (skipped
// for a held sample), the five biquad terms, one product per fir tap and the
// gain product; the two sums each end in a drain and a round step, and the
// scaling and gain products in a round step. the fir delay
// line is a ring of cells that rotates past the multiplier and then shifts in
// the new biquad output. a finished result waits in an output register, so
// the next item can be taken before the result is collected. configuration
// writes are always accepted and are meant to happen while the block is idle.
// depends on esfc_pkg, esfc_tap_cell, esfc_mac and the assertion macro header
`timescale 1ns / 1ps
`include "ecg_sample_filter_chain_core_defines.svh"

module ecg_sample_filter_chain_core #(
    parameter int TAP_COUNT = 36
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [esfc_pkg::RAW_W-1:0]           i_raw_code,
    input  logic [esfc_pkg::STATUS_W-1:0]        i_status_bits,
    // result item channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [esfc_pkg::SAMPLE_W-1:0] o_filtered_sample,
    output logic                                 o_sample_held,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [esfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [esfc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH = TAP_COUNT - 1;
    localparam int LAST  = DEPTH - 1;
    // counter covers both the fir taps and the five biquad terms
    localparam int CNT_W = ($clog2(TAP_COUNT) > 3) ? $clog2(TAP_COUNT) : 3;

    // configuration registers
    logic [23:0]        r_mid;
    logic [31:0]        r_scale;
    logic [23:0]        r_gain;
    logic signed [31:0] r_b0;
    logic signed [31:0] r_b1;
    logic signed [31:0] r_b2;
    logic signed [31:0] r_a1;
    logic signed [31:0] r_a2;

    // sequencer
    esfc_pkg::t_state   r_state;
    esfc_pkg::t_state   n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    // item and filter state
    logic [esfc_pkg::RAW_W-1:0]           r_raw;
    logic                                 r_held;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_x;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_last;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_xh0;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_xh1;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_yh0;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_yh1;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_y;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_f;

    // output register
    logic                                 r_out_valid;
    logic signed [esfc_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                 r_out_held;

    // datapath wires
    esfc_pkg::t_mac_op                    w_mac_op;
    esfc_pkg::t_cell_ctrl                 w_cell_ctrl;
    logic signed [esfc_pkg::OPND_W-1:0]   w_opnd_a;
    logic signed [esfc_pkg::OPND_W-1:0]   w_opnd_b;
    logic signed [esfc_pkg::PROD_W-1:0]   w_prod;
    logic signed [esfc_pkg::ACC_W-1:0]    w_acc;
    logic signed [24:0]                   w_centered;
    logic signed [esfc_pkg::SAMPLE_W-1:0] w_x_sat;
    logic signed [esfc_pkg::SAMPLE_W-1:0] w_sum_sat;
    logic signed [esfc_pkg::SAMPLE_W-1:0] w_g_sat;
    logic signed [esfc_pkg::SAMPLE_W-1:0] w_cell [DEPTH];
    logic                                 w_in_accept;
    logic                                 w_out_free;
    logic                                 w_in_ready_bit;

    assign w_in_accept    = i_in_valid && o_in_ready;
    assign w_out_free     = !r_out_valid || i_out_ready;
    assign w_in_ready_bit = i_status_bits[esfc_pkg::READY_BIT_POS];

    // ---------------------------------------------------------------
    // configuration port, never stalls
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= esfc_pkg::RST_ADC_MIDPOINT;
            r_scale <= esfc_pkg::RST_CONVERSION_SCALE;
            r_gain  <= esfc_pkg::RST_OUTPUT_GAIN;
            r_b0    <= esfc_pkg::RST_IIR_B0;
            r_b1    <= esfc_pkg::RST_IIR_B1;
            r_b2    <= esfc_pkg::RST_IIR_B2;
            r_a1    <= esfc_pkg::RST_IIR_A1;
            r_a2    <= esfc_pkg::RST_IIR_A2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                esfc_pkg::CFG_ADC_MIDPOINT:     r_mid   <= i_cfg_data[23:0];
                esfc_pkg::CFG_CONVERSION_SCALE: r_scale <= i_cfg_data;
                esfc_pkg::CFG_OUTPUT_GAIN:      r_gain  <= i_cfg_data[23:0];
                esfc_pkg::CFG_IIR_B0:           r_b0    <= i_cfg_data;
                esfc_pkg::CFG_IIR_B1:           r_b1    <= i_cfg_data;
                esfc_pkg::CFG_IIR_B2:           r_b2    <= i_cfg_data;
                esfc_pkg::CFG_IIR_A1:           r_a1    <= i_cfg_data;
                esfc_pkg::CFG_IIR_A2:           r_a2    <= i_cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // rounding of the three rescales, all half up then saturate
    // ---------------------------------------------------------------
    assign w_centered = $signed({1'b0, r_raw}) - $signed({1'b0, r_mid});

    always_comb begin
        // q.24 product back to q16.16
        w_x_sat   = esfc_pkg::sat32((esfc_pkg::ACC_W'(w_prod) + 72'sd8388608) >>> 24);
        // q2.30 x q16.16 sum back to q16.16
        w_sum_sat = esfc_pkg::sat32((w_acc + 72'sd536870912) >>> 30);
        // q8.16 gain back to q16.16
        w_g_sat   = esfc_pkg::sat32((esfc_pkg::ACC_W'(w_prod) + 72'sd32768) >>> 16);
    end

    // ---------------------------------------------------------------
    // sequencer: state register and next state / control
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esfc_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_mac_op    = '0;
        w_cell_ctrl = '0;
        w_opnd_a    = '0;
        w_opnd_b    = '0;
        case (r_state)
            esfc_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    // a held sample skips the conversion multiply
                    n_state = w_in_ready_bit ? esfc_pkg::ST_SCALE : esfc_pkg::ST_IIR;
                end
            end
            esfc_pkg::ST_SCALE: begin
                w_opnd_a = esfc_pkg::OPND_W'(w_centered);
                w_opnd_b = $signed({1'b0, r_scale});
                n_state  = esfc_pkg::ST_SCALE_RND;
            end
            esfc_pkg::ST_SCALE_RND: begin
                n_state = esfc_pkg::ST_IIR;
            end
            esfc_pkg::ST_IIR: begin
                w_mac_op.issue = 1'b1;
                w_mac_op.clear = (r_cnt == '0);
                case (r_cnt[2:0])
                    3'd0: begin
                        w_opnd_a = esfc_pkg::OPND_W'(r_x);
                        w_opnd_b = esfc_pkg::OPND_W'(r_b0);
                    end
                    3'd1: begin
                        w_opnd_a = esfc_pkg::OPND_W'(r_xh0);
                        w_opnd_b = esfc_pkg::OPND_W'(r_b1);
                    end
                    3'd2: begin
                        w_opnd_a = esfc_pkg::OPND_W'(r_xh1);
                        w_opnd_b = esfc_pkg::OPND_W'(r_b2);
                    end
                    3'd3: begin
                        w_opnd_a     = esfc_pkg::OPND_W'(r_yh0);
                        w_opnd_b     = esfc_pkg::OPND_W'(r_a1);
                        w_mac_op.sub = 1'b1;
                    end
                    default: begin
                        w_opnd_a     = esfc_pkg::OPND_W'(r_yh1);
                        w_opnd_b     = esfc_pkg::OPND_W'(r_a2);
                        w_mac_op.sub = 1'b1;
                    end
                endcase
                if (r_cnt == CNT_W'(esfc_pkg::IIR_TERMS - 1)) begin
                    n_cnt   = '0;
                    n_state = esfc_pkg::ST_IIR_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            esfc_pkg::ST_IIR_DRAIN: begin
                n_state = esfc_pkg::ST_IIR_RND;
            end
            esfc_pkg::ST_IIR_RND: begin
                n_cnt   = '0;
                n_state = esfc_pkg::ST_FIR;
            end
            esfc_pkg::ST_FIR: begin
                w_mac_op.issue = 1'b1;
                w_mac_op.clear = (r_cnt == '0);
                w_opnd_b       = esfc_pkg::OPND_W'(esfc_pkg::fir_coef(8'(r_cnt)));
                if (r_cnt == '0) begin
                    // newest tap is the fresh biquad output
                    w_opnd_a = esfc_pkg::OPND_W'(r_y);
                end else begin
                    // older taps come out of the ring head, one per cycle
                    w_opnd_a           = esfc_pkg::OPND_W'(w_cell[0]);
                    w_cell_ctrl.rotate = 1'b1;
                end
                if (r_cnt == CNT_W'(TAP_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = esfc_pkg::ST_FIR_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            esfc_pkg::ST_FIR_DRAIN: begin
                // ring is back in order; push the new sample in
                w_cell_ctrl.shift = 1'b1;
                n_state           = esfc_pkg::ST_FIR_RND;
            end
            esfc_pkg::ST_FIR_RND: begin
                n_state = esfc_pkg::ST_GAIN;
            end
            esfc_pkg::ST_GAIN: begin
                w_opnd_a = esfc_pkg::OPND_W'(r_f);
                w_opnd_b = $signed({9'b0, r_gain});
                n_state  = esfc_pkg::ST_GAIN_RND;
            end
            esfc_pkg::ST_GAIN_RND: begin
                // keep the gain operands so the product stays put while waiting
                w_opnd_a = esfc_pkg::OPND_W'(r_f);
                w_opnd_b = $signed({9'b0, r_gain});
                // wait here only while the output register is still full
                if (w_out_free) begin
                    n_state = esfc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = esfc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == esfc_pkg::ST_IDLE);

    // ---------------------------------------------------------------
    // item registers and filter history
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_raw  <= i_raw_code;
            r_held <= !w_in_ready_bit;
        end
        if (r_state == esfc_pkg::ST_FIR_RND) begin
            r_f <= w_sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_last <= '0;
            r_xh0  <= '0;
            r_xh1  <= '0;
            r_yh0  <= '0;
            r_yh1  <= '0;
            r_y    <= '0;
        end else begin
            if (w_in_accept && !w_in_ready_bit) begin
                r_x <= r_last;
            end
            if (r_state == esfc_pkg::ST_SCALE_RND) begin
                r_x    <= w_x_sat;
                r_last <= w_x_sat;
            end
            if (r_state == esfc_pkg::ST_IIR_RND) begin
                r_xh1 <= r_xh0;
                r_xh0 <= r_x;
                r_yh1 <= r_yh0;
                r_yh0 <= w_sum_sat;
                r_y   <= w_sum_sat;
            end
        end
    end

    // ---------------------------------------------------------------
    // shared multiply-accumulate unit
    // ---------------------------------------------------------------
    esfc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_mac_op),
        .i_opnd_a (w_opnd_a),
        .i_opnd_b (w_opnd_b),
        .o_prod   (w_prod),
        .o_acc    (w_acc)
    );

    // ---------------------------------------------------------------
    // fir delay line: ring of cells, cell 0 holds the newest past sample
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [esfc_pkg::SAMPLE_W-1:0] w_shift_in;
        logic signed [esfc_pkg::SAMPLE_W-1:0] w_rot_in;

        if (gi == 0) begin : g_head
            assign w_shift_in = r_y;
        end else begin : g_body
            assign w_shift_in = w_cell[gi-1];
        end

        if (gi == LAST) begin : g_tail
            assign w_rot_in = w_cell[0];
        end else begin : g_link
            assign w_rot_in = w_cell[gi+1];
        end

        esfc_tap_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_cell_ctrl),
            .i_shift_in (w_shift_in),
            .i_rot_in   (w_rot_in),
            .o_value    (w_cell[gi])
        );
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == esfc_pkg::ST_GAIN_RND && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == esfc_pkg::ST_GAIN_RND && w_out_free) begin
            r_out_sample <= w_g_sat;
            r_out_held   <= r_held;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_sample_held     = r_out_held;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // an accepted item makes the block busy on the next cycle
    `ESFC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_accept, !o_in_ready)
    // a new result only ever comes out of the gain rounding step
    `ESFC_ASSERT_HOLDS(a_result_source, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == esfc_pkg::ST_GAIN_RND)
    // the fir tap counter never runs past the last tap
    `ESFC_ASSERT_HOLDS(a_fir_cnt_range, i_clk, i_rst_n, r_state == esfc_pkg::ST_FIR,
        r_cnt <= CNT_W'(TAP_COUNT - 1))
    // the delay line only moves while the fir sum is being built
    `ESFC_ASSERT_HOLDS(a_cells_quiet, i_clk, i_rst_n,
        w_cell_ctrl.rotate || w_cell_ctrl.shift,
        r_state == esfc_pkg::ST_FIR || r_state == esfc_pkg::ST_FIR_DRAIN)

endmodule

FILE: sim/tb_ecg_sample_filter_chain_core.sv
// self-checking testbench for ecg_sample_filter_chain_core: bit-exact sv predictor,
// scoreboard class, random handshake idling and several register settings
// depends on esfc_pkg (types, register indexes, fir table) and the core rtl
`timescale 1ns / 1ps

module tb_ecg_sample_filter_chain_core;

    // block geometry and run shaping
    localparam int TAPS           = 36;
    localparam int MAX_WAIT       = 19;
    localparam int LONG_HOLD      = 400;        // receiver hold-off, in cycles
    localparam int HOLD_AT        = 200;        // result count that triggers the hold-off
    localparam int DRAIN_CYCLES   = TAPS + 24;  // quiet time after the last result
    localparam int FIRST_FREE_IDX = 8;          // first register index with no register
    localparam int LAST_IDX       = 2 ** esfc_pkg::CFG_IDX_W - 1;

    // status byte patterns
    localparam logic [esfc_pkg::STATUS_W-1:0] ST_NONE   = '0;
    localparam logic [esfc_pkg::STATUS_W-1:0] ST_READY  =
        esfc_pkg::STATUS_W'(1) << esfc_pkg::READY_BIT_POS;
    localparam logic [esfc_pkg::STATUS_W-1:0] ST_OTHERS = ~ST_READY;

    // wide signed math, enough for five q2.30 x q16.16 products summed exactly
    typedef logic signed [71:0] t_wide;
    localparam t_wide Q32_MAX = 72'sd2147483647;
    localparam t_wide Q32_MIN = -72'sd2147483648;
    localparam logic signed [31:0] COEF_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEF_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] UNITY_Q30  = 32'sd1073741824;

    typedef struct packed {
        logic signed [31:0] sample_q16;
        logic               held;
    } t_filt_result;

    typedef struct packed {
        logic [23:0]        midpoint;
        logic [31:0]        scale;
        logic [23:0]        gain;
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } t_filt_setting;

    typedef enum int {
        SET_DEFAULT,
        SET_FULL_SCALE,
        SET_ZERO_SCALE,
        SET_COEF_EDGE,
        SET_PASS_THROUGH,
        SET_RANDOM,
        SET_NEAR_DEFAULT
    } t_setting_kind;

    // phase plan: register setting, item count and which side idles
    localparam int N_PHASES    = 8;
    localparam int PAUSE_PHASE = 6;
    localparam int PAUSE_AT    = 200;
    localparam t_setting_kind PHASE_KIND [N_PHASES] = '{
        SET_DEFAULT, SET_FULL_SCALE, SET_ZERO_SCALE, SET_COEF_EDGE,
        SET_PASS_THROUGH, SET_RANDOM, SET_NEAR_DEFAULT, SET_DEFAULT
    };
    localparam int PHASE_ITEMS [N_PHASES] = '{400, 120, 80, 120, 200, 120, 400, 310};
    localparam bit PHASE_TX_IDLE [N_PHASES] = '{1, 1, 1, 1, 0, 1, 1, 0};
    localparam bit PHASE_RX_IDLE [N_PHASES] = '{1, 1, 1, 1, 0, 1, 0, 1};

    // expected result queue with field-by-field compare
    class t_sample_scoreboard;
        t_filt_result expected_q[$];
        int           errors;
        int           checked;
        int           held_seen;

        function new();
            errors    = 0;
            checked   = 0;
            held_seen = 0;
        endfunction

        function void note_input(t_filt_result r);
            expected_q = {expected_q, r};
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void check_result(logic signed [31:0] got_sample, logic got_held);
            t_filt_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: result with nothing expected, sample %0d held %0b",
                         $time, got_sample, got_held);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (exp_r.held) held_seen++;
            if (got_sample !== exp_r.sample_q16) begin
                errors++;
                $display("%0t ns: filtered_sample expected %0d got %0d",
                         $time, exp_r.sample_q16, got_sample);
            end
            if (got_held !== exp_r.held) begin
                errors++;
                $display("%0t ns: sample_held expected %0b got %0b",
                         $time, exp_r.held, got_held);
            end
        endfunction
    endclass

    // dut signals, every input known from time zero
    logic                                 i_clk;
    logic                                 i_rst_n       = 1'b0;
    logic                                 i_in_valid    = 1'b0;
    logic                                 o_in_ready;
    logic [esfc_pkg::RAW_W-1:0]           i_raw_code    = '0;
    logic [esfc_pkg::STATUS_W-1:0]        i_status_bits = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready   = 1'b0;
    logic signed [esfc_pkg::SAMPLE_W-1:0] o_filtered_sample;
    logic                                 o_sample_held;
    logic                                 i_cfg_valid   = 1'b0;
    logic                                 o_cfg_ready;
    logic [esfc_pkg::CFG_IDX_W-1:0]       i_cfg_index   = '0;
    logic [esfc_pkg::CFG_DATA_W-1:0]      i_cfg_data    = '0;

    ecg_sample_filter_chain_core #(
        .TAP_COUNT (TAPS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_raw_code        (i_raw_code),
        .i_status_bits     (i_status_bits),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_sample (o_filtered_sample),
        .o_sample_held     (o_sample_held),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    t_sample_scoreboard sb = new();

    // run bookkeeping and idling switches shared by the two sides
    int items_sent    = 0;
    int settings_done = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;

    // predictor copy of the registers, starting at their reset values
    logic [23:0]        cfg_midpoint = esfc_pkg::RST_ADC_MIDPOINT;
    logic [31:0]        cfg_scale    = esfc_pkg::RST_CONVERSION_SCALE;
    logic [23:0]        cfg_gain     = esfc_pkg::RST_OUTPUT_GAIN;
    logic signed [31:0] cfg_b0       = esfc_pkg::RST_IIR_B0;
    logic signed [31:0] cfg_b1       = esfc_pkg::RST_IIR_B1;
    logic signed [31:0] cfg_b2       = esfc_pkg::RST_IIR_B2;
    logic signed [31:0] cfg_a1       = esfc_pkg::RST_IIR_A1;
    logic signed [31:0] cfg_a2       = esfc_pkg::RST_IIR_A2;

    // predictor copy of the filter state, all zero after reset
    logic signed [31:0] last_ready_x = '0;
    logic signed [31:0] x_hist [2]        = '{default: '0};
    logic signed [31:0] y_hist [2]        = '{default: '0};
    logic signed [31:0] fir_line [TAPS-1] = '{default: '0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout: several times the slowest legal run
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [31:0] clamp_q32(input t_wide v);
        if (v > Q32_MAX) return Q32_MAX[31:0];
        if (v < Q32_MIN) return Q32_MIN[31:0];
        return v[31:0];
    endfunction

    // one converter word through scale, biquad, fir and gain; updates predictor state
    function automatic t_filt_result filter_step(input logic [23:0] raw,
                                                 input logic [7:0]  st);
        t_filt_result       r;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] f;
        t_wide              acc;
        r.held = ~st[esfc_pkg::READY_BIT_POS];
        if (r.held) begin
            // not ready: reuse the last scaled value, filters still run
            x = last_ready_x;
        end else begin
            acc = (t_wide'($signed({1'b0, raw})) - t_wide'($signed({1'b0, cfg_midpoint})))
                  * t_wide'($signed({1'b0, cfg_scale}));
            x = clamp_q32((acc + 72'sd8388608) >>> 24);
            last_ready_x = x;
        end
        // direct form i biquad, whole sum rounded half up once
        acc = t_wide'(cfg_b0) * t_wide'(x)
            + t_wide'(cfg_b1) * t_wide'(x_hist[0])
            + t_wide'(cfg_b2) * t_wide'(x_hist[1])
            - t_wide'(cfg_a1) * t_wide'(y_hist[0])
            - t_wide'(cfg_a2) * t_wide'(y_hist[1]);
        y = clamp_q32((acc + 72'sd536870912) >>> 30);
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = y;
        // fir: newest sample is tap zero, delay line holds the older ones
        acc = t_wide'(esfc_pkg::FIR_COEF[0]) * t_wide'(y);
        for (int k = 1; k < TAPS; k++) begin
            acc += t_wide'(esfc_pkg::FIR_COEF[k]) * t_wide'(fir_line[k-1]);
        end
        f = clamp_q32((acc + 72'sd536870912) >>> 30);
        for (int k = TAPS - 2; k > 0; k--) begin
            fir_line[k] = fir_line[k-1];
        end
        fir_line[0] = y;
        acc = t_wide'(f) * t_wide'($signed({1'b0, cfg_gain}));
        r.sample_q16 = clamp_q32((acc + 72'sd32768) >>> 16);
        return r;
    endfunction

    function automatic void apply_register(input logic [esfc_pkg::CFG_IDX_W-1:0]  idx,
                                           input logic [esfc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            esfc_pkg::CFG_ADC_MIDPOINT:     cfg_midpoint = data[23:0];
            esfc_pkg::CFG_CONVERSION_SCALE: cfg_scale    = data;
            esfc_pkg::CFG_OUTPUT_GAIN:      cfg_gain     = data[23:0];
            esfc_pkg::CFG_IIR_B0:           cfg_b0       = data;
            esfc_pkg::CFG_IIR_B1:           cfg_b1       = data;
            esfc_pkg::CFG_IIR_B2:           cfg_b2       = data;
            esfc_pkg::CFG_IIR_A1:           cfg_a1       = data;
            esfc_pkg::CFG_IIR_A2:           cfg_a2       = data;
            default: ;  // no register behind this index
        endcase
    endfunction

    function automatic int draw_wait(input bit enable);
        return enable ? int'($urandom_range(0, MAX_WAIT)) : 0;
    endfunction

    function automatic t_filt_setting make_setting(input t_setting_kind kind);
        t_filt_setting s;
        s.midpoint = esfc_pkg::RST_ADC_MIDPOINT;
        s.scale    = esfc_pkg::RST_CONVERSION_SCALE;
        s.gain     = esfc_pkg::RST_OUTPUT_GAIN;
        s.b0       = esfc_pkg::RST_IIR_B0;
        s.b1       = esfc_pkg::RST_IIR_B1;
        s.b2       = esfc_pkg::RST_IIR_B2;
        s.a1       = esfc_pkg::RST_IIR_A1;
        s.a2       = esfc_pkg::RST_IIR_A2;
        case (kind)
            SET_FULL_SCALE: begin
                // huge conversion and gain, scaled value and output clip often
                s.midpoint = '0;
                s.scale    = '1;
                s.gain     = '1;
            end
            SET_ZERO_SCALE: begin
                s.midpoint = '1;
                s.scale    = '0;
                s.gain     = '0;
            end
            SET_COEF_EDGE: begin
                // unstable biquad at the coefficient limits, iir output saturates
                s.midpoint = '1;
                s.scale    = '1;
                s.b0       = COEF_MAX;
                s.b1       = COEF_MIN;
                s.b2       = COEF_MAX;
                s.a1       = COEF_MIN;
                s.a2       = COEF_MAX;
            end
            SET_PASS_THROUGH: begin
                // biquad reduced to a wire, so the fir sees the scaled samples
                s.midpoint = 24'($urandom);
                s.scale    = $urandom_range(1 << 20, 1 << 26);
                s.gain     = 24'($urandom_range(0, 1 << 18));
                s.b0       = UNITY_Q30;
                s.b1       = '0;
                s.b2       = '0;
                s.a1       = '0;
                s.a2       = '0;
            end
            SET_RANDOM: begin
                s.midpoint = 24'($urandom);
                s.scale    = $urandom;
                s.gain     = 24'($urandom);
                s.b0       = $urandom;
                s.b1       = $urandom;
                s.b2       = $urandom;
                s.a1       = $urandom;
                s.a2       = $urandom;
            end
            SET_NEAR_DEFAULT: begin
                s.midpoint = 24'($urandom);
                s.scale    = esfc_pkg::RST_CONVERSION_SCALE
                             + $urandom_range(0, 1 << 24) - (1 << 23);
                s.gain     = 24'($urandom_range(1 << 14, 1 << 18));
            end
            default: ;
        endcase
        return s;
    endfunction

    // raw codes: mostly near the midpoint or anywhere, some at the code range ends
    function automatic logic [23:0] pick_raw();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return cfg_midpoint + 24'($urandom_range(0, 8191)) - 24'd4096;
        if (sel < 8) return 24'($urandom);
        if (sel == 8) begin
            if ($urandom_range(0, 1) == 0) return 24'($urandom_range(0, 15));
            return 24'hFF_FFFF - 24'($urandom_range(0, 15));
        end
        return cfg_midpoint + 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
    endfunction

    // status: ready most of the time, the other bits random noise
    function automatic logic [7:0] pick_status();
        logic [7:0] st;
        st = 8'($urandom);
        st[esfc_pkg::READY_BIT_POS] = ($urandom_range(0, 99) < 85);
        return st;
    endfunction

    // offer one item, hold it until taken, then predict its result
    task automatic send_item(input logic [23:0] raw, input logic [7:0] st);
        int gap;
        gap = draw_wait(tx_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_code    <= raw;
        i_status_bits <= st;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(filter_step(raw, st));
        items_sent++;
    endtask

    // drop valid and wait until every expected result has been collected
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [esfc_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [esfc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // all eight registers, junk in the unused upper bits of the narrow ones,
    // then a write to an index with no register that must change nothing
    task automatic program_setting(input t_filt_setting s);
        cfg_write(esfc_pkg::CFG_ADC_MIDPOINT,     {8'($urandom), s.midpoint});
        cfg_write(esfc_pkg::CFG_CONVERSION_SCALE, s.scale);
        cfg_write(esfc_pkg::CFG_OUTPUT_GAIN,      {8'($urandom), s.gain});
        cfg_write(esfc_pkg::CFG_IIR_B0,           s.b0);
        cfg_write(esfc_pkg::CFG_IIR_B1,           s.b1);
        cfg_write(esfc_pkg::CFG_IIR_B2,           s.b2);
        cfg_write(esfc_pkg::CFG_IIR_A1,           s.a1);
        cfg_write(esfc_pkg::CFG_IIR_A2,           s.a2);
        cfg_write(esfc_pkg::CFG_IDX_W'($urandom_range(FIRST_FREE_IDX, LAST_IDX)), $urandom);
        settings_done++;
    endtask

    // result side: random ready gaps, one long hold-off so the block backs up
    initial begin : result_sink
        int gap;
        int seen;
        seen = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = (seen == HOLD_AT) ? LONG_HOLD : draw_wait(rx_idle_on);
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_filtered_sample, o_sample_held);
            seen++;
        end
    end

    initial begin : stimulus
        // reset held low from the start, released at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset register values
        send_item(24'h12_3456, ST_NONE);              // held before any ready sample
        send_item(esfc_pkg::RST_ADC_MIDPOINT, ST_READY); // centered code, zero input
        send_item(24'h00_0000, ST_READY);             // lowest raw code
        send_item(24'hFF_FFFF, ST_READY | ST_OTHERS); // highest code, all status bits
        send_item(24'hAB_CDEF, ST_OTHERS);            // not ready with every other bit set
        send_item(esfc_pkg::RST_ADC_MIDPOINT + 24'd1, ST_READY);
        send_item(esfc_pkg::RST_ADC_MIDPOINT - 24'd1, ST_READY | ST_OTHERS);
        send_item(24'h80_0000, ST_READY);
        send_item(24'hFF_FFFF, ST_READY);             // step up
        repeat (4) send_item(24'h00_0000, ST_NONE);   // held value keeps feeding filters
        send_item(24'h00_0000, ST_READY);             // step down
        repeat (3) begin
            send_item(24'hFF_FFFF, ST_READY);
            send_item(24'h00_0000, ST_READY);
        end

        // random phases, registers rewritten only once the block has drained
        for (int p = 0; p < N_PHASES; p++) begin
            wait_for_drain();
            program_setting(make_setting(PHASE_KIND[p]));
            tx_idle_on = PHASE_TX_IDLE[p];
            rx_idle_on = PHASE_RX_IDLE[p];
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                // sender pause until every expected result is back
                if (p == PAUSE_PHASE && n == PAUSE_AT) wait_for_drain();
                send_item(pick_raw(), pick_status());
            end
        end

        // drain, then stay quiet long enough to catch any stray result
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items (%0d held) over %0d register settings",
                 items_sent, sb.held_seen, settings_done);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/esfc_pkg.sv
design/esfc_tap_cell.sv
design/esfc_mac.sv
design/ecg_sample_filter_chain_core.sv
sim/tb_ecg_sample_filter_chain_core.sv
